>>> rtl/core/lsc_pkg.sv
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared constants for the line segment clusterer.
// ----------------------------------------------------------------------------
package lsc_pkg;

  localparam int unsigned AngleW     = 13;
  localparam int unsigned JoinW      = 11;
  localparam int unsigned ClusterW   = 8;
  localparam int unsigned CfgW       = 13;
  localparam int unsigned CordicW    = 36;
  localparam int unsigned ZW         = 19;
  localparam int unsigned CordicSteps = 15;
  localparam int unsigned StepW      = 4;

  localparam logic [AngleW-1:0] HalfTurn16  = 13'd2880;
  localparam logic [AngleW-1:0] FullTurn16  = 13'd5760;
  localparam logic signed [ZW-1:0] FullTurn256 = 19'sd92160;
  localparam logic signed [ZW-1:0] HalfTurn256 = 19'sd46080;

  localparam logic [AngleW-1:0] AngleLimitRst   = 13'd800;
  localparam logic [JoinW-1:0]  JoinDistanceRst = 11'd35;

  typedef enum logic {
    CFG_ANGLE_LIMIT   = 1'b0,
    CFG_JOIN_DISTANCE = 1'b1
  } cfg_idx_e;

  function automatic logic signed [ZW-1:0] atan_lut(input logic [StepW-1:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      4'd0:    v = 19'sd11520;
      4'd1:    v = 19'sd6801;
      4'd2:    v = 19'sd3593;
      4'd3:    v = 19'sd1824;
      4'd4:    v = 19'sd916;
      4'd5:    v = 19'sd458;
      4'd6:    v = 19'sd229;
      4'd7:    v = 19'sd115;
      4'd8:    v = 19'sd57;
      4'd9:    v = 19'sd29;
      4'd10:   v = 19'sd14;
      4'd11:   v = 19'sd7;
      4'd12:   v = 19'sd4;
      4'd13:   v = 19'sd2;
      4'd14:   v = 19'sd1;
      default: v = 19'sd0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/core/lsc_cordic.sv
// ----------------------------------------------------------------------------
// lsc_cordic
// Iterative vectoring CORDIC: segment direction in 1/16 degree, one step/cycle.
// ----------------------------------------------------------------------------
module lsc_cordic #(
  parameter int unsigned COORD_BITS = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [COORD_BITS-1:0]         sx_i,
  input  logic [COORD_BITS-1:0]         sy_i,
  input  logic [COORD_BITS-1:0]         ex_i,
  input  logic [COORD_BITS-1:0]         ey_i,
  output logic                          done_o,
  output logic [lsc_pkg::AngleW-1:0]    angle_o
);

  localparam int unsigned W = lsc_pkg::CordicW;
  localparam int unsigned ZW = lsc_pkg::ZW;

  logic                 run_q, run_d;
  logic                 done_q, done_d;
  logic signed [W-1:0]  x_q, x_d, y_q, y_d;
  logic signed [ZW-1:0] z_q, z_d;
  logic [lsc_pkg::StepW-1:0] i_q, i_d;
  logic [lsc_pkg::AngleW-1:0] ang_q, ang_d;

  logic signed [W-1:0]  dx, dy, xs, ys;
  logic signed [ZW-1:0] zf;
  logic signed [ZW:0]   zr;

  always_comb begin
    dx = W'(signed'({1'b0, ex_i})) - W'(signed'({1'b0, sx_i}));
    dy = W'(signed'({1'b0, ey_i})) - W'(signed'({1'b0, sy_i}));
    xs = x_q >>> i_q;
    ys = y_q >>> i_q;
    zf = (z_q < 0) ? z_q + lsc_pkg::FullTurn256 : z_q;
    zr = ((ZW+1)'(zf) + (ZW+1)'(8)) >>> 4;
    run_d  = run_q;
    done_d = 1'b0;
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    i_d = i_q;
    ang_d = ang_q;
    if (start_i) begin
      i_d = '0;
      if (dx == 0 && dy == 0) begin
        ang_d  = '0;
        done_d = 1'b1;
        run_d  = 1'b0;
      end else begin
        run_d = 1'b1;
        if (dx < 0) begin
          x_d = (-dx) <<< 8;
          y_d = (-dy) <<< 8;
          z_d = lsc_pkg::HalfTurn256;
        end else begin
          x_d = dx <<< 8;
          y_d = dy <<< 8;
          z_d = '0;
        end
      end
    end else if (run_q) begin
      if (y_q == 0 || i_q == 4'(lsc_pkg::CordicSteps)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
        ang_d  = (zr[lsc_pkg::AngleW-1:0] >= lsc_pkg::FullTurn16) ?
                 zr[lsc_pkg::AngleW-1:0] - lsc_pkg::FullTurn16 : zr[lsc_pkg::AngleW-1:0];
      end else begin
        if (y_q > 0) begin
          x_d = x_q + ys;
          y_d = y_q - xs;
          z_d = z_q + lsc_pkg::atan_lut(i_q);
        end else begin
          x_d = x_q - ys;
          y_d = y_q + xs;
          z_d = z_q - lsc_pkg::atan_lut(i_q);
        end
        i_d = i_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
    i_q <= i_d;
    ang_q <= ang_d;
  end

  assign done_o  = done_q;
  assign angle_o = ang_q;

endmodule

>>> rtl/core/lsc_dist.sv
// ----------------------------------------------------------------------------
// lsc_dist
// Registered minimum squared endpoint distance between two segments.
// ----------------------------------------------------------------------------
module lsc_dist #(
  parameter int unsigned COORD_BITS = 10
) (
  input  logic                      clk_i,
  input  logic [4*COORD_BITS-1:0]   a_i,
  input  logic [4*COORD_BITS-1:0]   b_i,
  output logic [2*COORD_BITS:0]     dist_o
);

  localparam int unsigned C = COORD_BITS;
  localparam int unsigned DW = 2*C + 1;

  logic [C-1:0] ax [2];
  logic [C-1:0] ay [2];
  logic [C-1:0] bx [2];
  logic [C-1:0] by [2];
  logic [DW-1:0] sq_q [4];
  logic [DW-1:0] m01, m23;

  function automatic logic [2*C-1:0] sqd(input logic [C-1:0] p, input logic [C-1:0] q);
    logic [C-1:0] d;
    d = (p > q) ? p - q : q - p;
    return d * d;
  endfunction

  // segment packing: {ey, ex, sy, sx}
  always_comb begin
    ax[0] = a_i[C-1:0];   ay[0] = a_i[2*C-1:C];
    ax[1] = a_i[3*C-1:2*C]; ay[1] = a_i[4*C-1:3*C];
    bx[0] = b_i[C-1:0];   by[0] = b_i[2*C-1:C];
    bx[1] = b_i[3*C-1:2*C]; by[1] = b_i[4*C-1:3*C];
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      sq_q[k] <= DW'(sqd(ax[k/2], bx[k%2])) + DW'(sqd(ay[k/2], by[k%2]));
    end
  end

  assign m01 = (sq_q[1] < sq_q[0]) ? sq_q[1] : sq_q[0];
  assign m23 = (sq_q[3] < sq_q[2]) ? sq_q[3] : sq_q[2];
  assign dist_o = (m23 < m01) ? m23 : m01;

endmodule

>>> rtl/core/line_segment_clusterer.sv
// ----------------------------------------------------------------------------
// line_segment_clusterer
// Assigns each incoming line segment to a cluster of earlier segments.
// ----------------------------------------------------------------------------
// Usage:
//   Drive start_i with a segment (start_x/y, end_x/y) and first_of_set_i;
//   the transaction is taken when start_i is high and busy_o is low.
//   busy_o stays high until the result strobe done_o, which carries
//   cluster_index_o, opened_new_o and dropped_o for exactly one cycle.
//   The receiver cannot stall; the result must be captured on that cycle.
// Flow: the direction is found by an iterative CORDIC, then the segment
//   store memory is scanned one entry per cycle through a memory read
//   followed by the angle test and the endpoint distance in parallel.
//   A full store (MAX_SEGMENTS entries, 256 by default) skips both and
//   answers "dropped" straight from the drop state.
// Memory: one synchronous RAM holds {cluster, angle, endpoints} per entry;
//   only entries below the fill count are ever used, so no clearing pass.
// Reset: counters clear, registers take angle_limit 800, join_distance 35.
//   first_of_set_i empties the store by zeroing both counters.
// Configuration: cfg_we_i, cfg_idx_i, cfg_data_i; write only while idle.
// ----------------------------------------------------------------------------
module line_segment_clusterer #(
  parameter int unsigned MAX_SEGMENTS = 256,
  parameter int unsigned COORD_BITS   = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [lsc_pkg::CfgW-1:0]      cfg_data_i,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          first_of_set_i,
  input  logic [COORD_BITS-1:0]         start_x_i,
  input  logic [COORD_BITS-1:0]         start_y_i,
  input  logic [COORD_BITS-1:0]         end_x_i,
  input  logic [COORD_BITS-1:0]         end_y_i,
  output logic                          done_o,
  output logic [lsc_pkg::ClusterW-1:0]  cluster_index_o,
  output logic                          opened_new_o,
  output logic                          dropped_o
);

  localparam int unsigned AW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned CW  = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned SW  = 4*COORD_BITS;
  localparam int unsigned DW  = 2*COORD_BITS + 1;
  localparam int unsigned ANW = lsc_pkg::AngleW;
  localparam int unsigned KW  = CW;
  localparam int unsigned EW  = KW + ANW + SW;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ANGLE, ST_SCAN, ST_DECIDE, ST_DROP
  } state_e;

  state_e state_q;
  logic [ANW-1:0]             angle_limit_q;
  logic [lsc_pkg::JoinW-1:0]  join_q;
  logic [CW-1:0]              seg_cnt_q;
  logic [KW-1:0]              clu_cnt_q;
  logic [SW-1:0]              seg_q;
  logic [ANW-1:0]             ang_q;
  logic [CW-1:0]              rd_ptr_q;
  logic                       v1_q, v2_q;
  logic [KW-1:0]              clu1_q;
  logic                       hit1_q;
  logic                       found_q;
  logic [DW-1:0]              best_q;
  logic [KW-1:0]              best_clu_q;
  logic                       done_q, opened_q, dropped_q;
  logic [lsc_pkg::ClusterW-1:0] cidx_q;

  // segment memory
  logic [EW-1:0] mem [MAX_SEGMENTS];
  logic [EW-1:0] rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;

  logic          cor_start, cor_done;
  logic [ANW-1:0] cor_angle;
  logic [DW-1:0] gap_min;
  logic [ANW-1:0] d_abs, off, diff, r_ang;
  logic [SW-1:0] in_seg;
  logic [2*lsc_pkg::JoinW-1:0] lim;
  logic          take;
  logic          joins;
  logic [KW-1:0] new_clu;

  assign in_seg = {end_y_i, end_x_i, start_y_i, start_x_i};

  lsc_cordic #(.COORD_BITS(COORD_BITS)) u_cordic (
    .clk_i, .rst_ni,
    .start_i (cor_start),
    .sx_i (start_x_i), .sy_i (start_y_i), .ex_i (end_x_i), .ey_i (end_y_i),
    .done_o  (cor_done),
    .angle_o (cor_angle)
  );

  lsc_dist #(.COORD_BITS(COORD_BITS)) u_dist (
    .clk_i,
    .a_i    (rdata_q[SW-1:0]),
    .b_i    (seg_q),
    .dist_o (gap_min)
  );

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_q <= mem[rd_ptr_q[AW-1:0]];
  end

  // angle test on the read entry
  assign r_ang = rdata_q[SW +: ANW];
  assign d_abs = (ang_q > r_ang) ? ang_q - r_ang : r_ang - ang_q;
  assign off   = (d_abs > lsc_pkg::HalfTurn16) ? d_abs - lsc_pkg::HalfTurn16
                                               : lsc_pkg::HalfTurn16 - d_abs;
  assign diff  = lsc_pkg::HalfTurn16 - off;

  // distance, angle hit and cluster of one entry are all registered from its read data
  assign lim  = (2*lsc_pkg::JoinW)'(join_q) * (2*lsc_pkg::JoinW)'(join_q);
  assign take = v2_q && hit1_q && (!found_q || gap_min < best_q ||
                (gap_min == best_q && clu1_q < best_clu_q));
  assign joins   = found_q && ((2*lsc_pkg::JoinW)'(best_q) < lim);
  assign new_clu = joins ? best_clu_q : clu_cnt_q;

  wire accept = start_i && (state_q == ST_IDLE);
  assign cor_start = accept;
  wire eff_cnt_zero = first_of_set_i;

  assign mem_we    = (state_q == ST_DECIDE);
  assign mem_waddr = seg_cnt_q[AW-1:0];
  assign mem_wdata = {new_clu, ang_q, seg_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      angle_limit_q <= lsc_pkg::AngleLimitRst;
      join_q        <= lsc_pkg::JoinDistanceRst;
      seg_cnt_q     <= '0;
      clu_cnt_q     <= '0;
      v1_q          <= 1'b0;
      v2_q          <= 1'b0;
      done_q        <= 1'b0;
      found_q       <= 1'b0;
      cidx_q        <= '0;
      opened_q      <= 1'b0;
      dropped_q     <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (cfg_we_i) begin
        case (lsc_pkg::cfg_idx_e'(cfg_idx_i))
          lsc_pkg::CFG_ANGLE_LIMIT:   angle_limit_q <= cfg_data_i;
          lsc_pkg::CFG_JOIN_DISTANCE: join_q <= cfg_data_i[lsc_pkg::JoinW-1:0];
          default: ;
        endcase
      end
      // scan pipeline: read -> angle test and distance in parallel
      v1_q   <= (state_q == ST_SCAN) && (rd_ptr_q < seg_cnt_q);
      v2_q   <= v1_q;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (eff_cnt_zero) begin
              seg_cnt_q <= '0;
              clu_cnt_q <= '0;
            end
            found_q <= 1'b0;
            state_q <= (!eff_cnt_zero && seg_cnt_q >= CW'(MAX_SEGMENTS)) ?
                       ST_DROP : ST_ANGLE;
          end
        end
        ST_ANGLE: begin
          if (cor_done) state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          if (take) found_q <= 1'b1;
          if (rd_ptr_q >= seg_cnt_q && !v1_q && !v2_q) state_q <= ST_DECIDE;
        end
        ST_DECIDE: begin
          seg_cnt_q <= seg_cnt_q + CW'(1);
          if (!joins) clu_cnt_q <= clu_cnt_q + KW'(1);
          cidx_q    <= new_clu[lsc_pkg::ClusterW-1:0];
          opened_q  <= !joins;
          dropped_q <= 1'b0;
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        ST_DROP: begin
          cidx_q    <= '0;
          opened_q  <= 1'b0;
          dropped_q <= 1'b1;
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) seg_q <= in_seg;
    if (cor_done) ang_q <= cor_angle;
    rd_ptr_q <= (state_q == ST_SCAN) ? ((rd_ptr_q < seg_cnt_q) ? rd_ptr_q + CW'(1) : rd_ptr_q)
                                     : '0;
    hit1_q <= diff < angle_limit_q;
    clu1_q <= rdata_q[SW+ANW +: KW];
    if (state_q == ST_SCAN && take) begin
      best_q     <= gap_min;
      best_clu_q <= clu1_q;
    end
  end

  assign busy_o          = (state_q != ST_IDLE);
  assign done_o          = done_q;
  assign cluster_index_o = cidx_q;
  assign opened_new_o    = opened_q;
  assign dropped_o       = dropped_q;

endmodule
